### rtl/core/tal_pkg.sv
// ----------------------------------------------------------------------------
// tal_pkg
// Shared types, codes and conversion helpers of the temperature alarm logger.
// ----------------------------------------------------------------------------
package tal_pkg;

   // default configuration
   localparam int LOG_BYTES_DEFAULT        = 512;
   localparam int TICKS_PER_SECOND_DEFAULT = 4;

   // fixed field widths
   localparam int ADDR_W = 9;
   localparam int TEMP_W = 6;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // bytes in one log record
   localparam int RECORD_BYTES = 4;

   // operation codes
   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_REFERENCE = 2'd1,
      OP_SENSOR    = 2'd2,
      OP_CLEAR     = 2'd3
   } tal_op_type;

   // record byte order
   typedef enum logic [1:0] {
      BYTE_HOUR    = 2'd0,
      BYTE_MINUTE  = 2'd1,
      BYTE_CHANNEL = 2'd2,
      BYTE_SAMPLE  = 2'd3
   } tal_byte_type;

   // input beat
   typedef struct packed {
      logic [1:0] operation;
      logic [1:0] channel;
      logic [7:0] sample;
   } tal_req_type;

   // result beat
   typedef struct packed {
      logic              log_write;
      logic [ADDR_W-1:0] log_address;
      logic [7:0]        log_byte;
      logic              last;
      logic [TEMP_W-1:0] temperature;
      logic              alarm;
      logic [3:0]        led_mask;
      logic              log_full;
      logic [4:0]        hours;
      logic [5:0]        minutes;
   } tal_rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic              record;
      logic [ADDR_W-1:0] base;
      logic [1:0]        channel;
      logic [7:0]        sample;
      logic [TEMP_W-1:0] temperature;
      logic              alarm;
      logic [3:0]        led_mask;
      logic              log_full;
      logic [4:0]        hours;
      logic [5:0]        minutes;
   } tal_desc_type;

   // whole volts of a reading, floor(s*5/255): count of thresholds 51*k passed
   function automatic logic [2:0] volts_of(input logic [7:0] s);
      logic [2:0] v;
      v = 3'd0;
      if (s >= 8'd51)  v = 3'd1;
      if (s >= 8'd102) v = 3'd2;
      if (s >= 8'd153) v = 3'd3;
      if (s >= 8'd204) v = 3'd4;
      if (s == 8'd255) v = 3'd5;
      return v;
   endfunction

   // reference temperature 9*v+5
   function automatic logic [TEMP_W-1:0] reference_of(input logic [7:0] s);
      return TEMP_W'(9 * volts_of(s) + 5);
   endfunction

   // sensor temperature 7*v+15
   function automatic logic [TEMP_W-1:0] sensor_of(input logic [7:0] s);
      return TEMP_W'(7 * volts_of(s) + 15);
   endfunction

endpackage

### rtl/core/tal_front.sv
// ----------------------------------------------------------------------------
// tal_front
// Accepts input beats, keeps the clock, reference, log pointer and LEDs, and
// classifies each item into a descriptor for the back end.
// ----------------------------------------------------------------------------
module tal_front
   import tal_pkg::*;
#(
   parameter int LOG_BYTES        = LOG_BYTES_DEFAULT,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  tal_req_type  req_item,
   output tal_desc_type desc
);

   localparam int PTR_W  = $clog2(LOG_BYTES + 1);
   localparam int TICK_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

   logic [TICK_W-1:0]  quarter_ff, quarter_in;
   logic [3:0]         sec_u_ff, sec_u_in;
   logic [2:0]         sec_t_ff, sec_t_in;
   logic [3:0]         min_u_ff, min_u_in;
   logic [2:0]         min_t_ff, min_t_in;
   logic [3:0]         hr_u_ff, hr_u_in;
   logic [1:0]         hr_t_ff, hr_t_in;
   logic [TEMP_W-1:0]  ref_ff, ref_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [3:0]         led_ff, led_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff <= '0;
         sec_u_ff   <= 4'd0;
         sec_t_ff   <= 3'd0;
         min_u_ff   <= 4'd9;
         min_t_ff   <= 3'd4;
         hr_u_ff    <= 4'd8;
         hr_t_ff    <= 2'd0;
         ref_ff     <= '0;
         ptr_ff     <= '0;
         led_ff     <= 4'd0;
      end else if (accept) begin
         quarter_ff <= quarter_in;
         sec_u_ff   <= sec_u_in;
         sec_t_ff   <= sec_t_in;
         min_u_ff   <= min_u_in;
         min_t_ff   <= min_t_in;
         hr_u_ff    <= hr_u_in;
         hr_t_ff    <= hr_t_in;
         ref_ff     <= ref_in;
         ptr_ff     <= ptr_in;
         led_ff     <= led_in;
      end
   end

   // next state and descriptor for the beat on the input
   always_comb begin
      logic [TEMP_W-1:0] temp;
      logic              alarm;
      logic              full;
      logic              record;
      logic [3:0]        ch_bit;

      quarter_in = quarter_ff;
      sec_u_in   = sec_u_ff;
      sec_t_in   = sec_t_ff;
      min_u_in   = min_u_ff;
      min_t_in   = min_t_ff;
      hr_u_in    = hr_u_ff;
      hr_t_in    = hr_t_ff;
      ref_in     = ref_ff;
      ptr_in     = ptr_ff;
      led_in     = led_ff;
      temp       = '0;
      alarm      = 1'b0;
      record     = 1'b0;
      ch_bit     = 4'b0001 << req_item.channel;

      case (req_item.operation)
         OP_TICK: begin
            if (quarter_ff == TICK_W'(TICKS_PER_SECOND - 1)) begin
               quarter_in = '0;
               // one second forward, BCD carry chain
               sec_u_in = sec_u_ff + 4'd1;
               if (sec_u_in >= 4'd10) begin
                  sec_u_in = 4'd0;
                  sec_t_in = sec_t_in + 3'd1;
               end
               if (sec_t_in >= 3'd6) begin
                  sec_t_in = 3'd0;
                  min_u_in = min_u_in + 4'd1;
               end
               if (min_u_in >= 4'd10) begin
                  min_u_in = 4'd0;
                  min_t_in = min_t_in + 3'd1;
               end
               if (min_t_in >= 3'd6) begin
                  min_t_in = 3'd0;
                  hr_u_in  = hr_u_in + 4'd1;
               end
               if (hr_u_in >= 4'd10) begin
                  hr_u_in = 4'd0;
                  hr_t_in = hr_t_in + 2'd1;
               end
               if ((hr_t_in == 2'd2 && hr_u_in >= 4'd4) || hr_t_in == 2'd3) begin
                  hr_t_in  = 2'd0;
                  hr_u_in  = 4'd0;
                  min_t_in = 3'd0;
                  min_u_in = 4'd0;
                  sec_t_in = 3'd0;
                  sec_u_in = 4'd0;
               end
            end else begin
               quarter_in = quarter_ff + TICK_W'(1);
            end
         end
         OP_REFERENCE: begin
            ref_in = reference_of(req_item.sample);
            temp   = ref_in;
         end
         OP_CLEAR: begin
            ptr_in = '0;
            led_in = 4'd0;
         end
         default: begin
            temp  = sensor_of(req_item.sample);
            alarm = (temp < ref_ff);
         end
      endcase

      // room check on the pointer after this operation's own effect
      full = ((PTR_W + 1)'(ptr_in) + (PTR_W + 1)'(RECORD_BYTES)) >
             (PTR_W + 1)'(LOG_BYTES);

      // sensor outcome on LEDs and pointer
      if (req_item.operation == OP_SENSOR) begin
         if (alarm) begin
            if (!full) begin
               record = 1'b1;
               led_in = led_ff | ch_bit;
               ptr_in = ptr_ff + PTR_W'(RECORD_BYTES);
            end
         end else begin
            led_in = led_ff & ~ch_bit;
         end
      end

      desc.record      = record;
      desc.base        = ADDR_W'(ptr_ff);
      desc.channel     = req_item.channel;
      desc.sample      = req_item.sample;
      desc.temperature = temp;
      desc.alarm       = alarm;
      desc.led_mask    = led_in;
      desc.log_full    = full;
      desc.hours       = 5'(hr_t_in) * 5'd10 + 5'(hr_u_in);
      desc.minutes     = 6'(min_t_in) * 6'd10 + 6'(min_u_in);
   end

endmodule

### rtl/core/tal_queue.sv
// ----------------------------------------------------------------------------
// tal_queue
// Short descriptor queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tal_queue
   import tal_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tal_desc_type wr_data,
   output logic         full,
   input  logic         pop,
   output tal_desc_type rd_data,
   output logic         empty
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tal_desc_type       slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[head_ff];

   // pointer and count update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + IDX_W'(1);
      end
      if (do_pop) begin
         head_in = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[tail_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/tal_back.sv
// ----------------------------------------------------------------------------
// tal_back
// Takes descriptors from the queue and plays them out as result beats: four
// record bytes for a logged alarm, one status beat otherwise.
// ----------------------------------------------------------------------------
module tal_back
   import tal_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  tal_desc_type q_data,
   input  logic         q_empty,
   output logic         q_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output tal_rsp_type  rsp_item
);

   tal_desc_type cur_ff, cur_in;
   logic         valid_ff, valid_in;
   logic [1:0]   beat_ff, beat_in;
   logic         is_last;

   assign rsp_empty = !valid_ff;
   assign is_last   = !cur_ff.record || (beat_ff == BYTE_SAMPLE);

   // beat sequencing and refill from the queue
   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      beat_in  = beat_ff;
      q_pop    = 1'b0;
      if (!valid_ff || (rsp_pop && is_last)) begin
         q_pop    = !q_empty;
         valid_in = !q_empty;
         cur_in   = q_data;
         beat_in  = 2'd0;
      end else if (rsp_pop) begin
         beat_in = beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // result fields from the held descriptor
   always_comb begin
      logic [7:0] data;
      case (beat_ff)
         BYTE_HOUR:    data = 8'(cur_ff.hours);
         BYTE_MINUTE:  data = 8'(cur_ff.minutes);
         BYTE_CHANNEL: data = 8'(cur_ff.channel) + 8'd1;
         BYTE_SAMPLE:  data = cur_ff.sample;
         default:      data = 8'd0;
      endcase
      rsp_item.log_write   = cur_ff.record;
      rsp_item.log_address = cur_ff.record ? cur_ff.base + ADDR_W'(beat_ff) : '0;
      rsp_item.log_byte    = cur_ff.record ? data : 8'd0;
      rsp_item.last        = is_last;
      rsp_item.temperature = cur_ff.temperature;
      rsp_item.alarm       = cur_ff.alarm;
      rsp_item.led_mask    = cur_ff.led_mask;
      rsp_item.log_full    = cur_ff.log_full;
      rsp_item.hours       = cur_ff.hours;
      rsp_item.minutes     = cur_ff.minutes;
   end

endmodule

### rtl/core/temperature_alarm_logger.sv
// ----------------------------------------------------------------------------
// temperature_alarm_logger
// BCD time of day, reference and sensor conversion, alarm LEDs and a byte
// log written as four-byte records.
// ----------------------------------------------------------------------------
//  channel   ports                          beat
//  input     req_push, req_full, req_item   operation, channel, sample
//  result    rsp_pop, rsp_empty, rsp_item   log byte, address and status
//
// The front end takes one input beat per cycle while the descriptor queue
// has room; the back end sends one result beat per cycle while rsp_pop is
// high, so a logged alarm takes four result beats and any other item one.
// A result is registered in the queue, then in the back end's held descriptor.
// Synchronous reset sets the clock to 08:49:00 and clears reference, log
// pointer and LEDs. Either side may stall; the queue absorbs it until full.
// ----------------------------------------------------------------------------
module temperature_alarm_logger
   import tal_pkg::*;
#(
   parameter int LOG_BYTES        = LOG_BYTES_DEFAULT,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  tal_req_type req_item,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output tal_rsp_type rsp_item
);

   tal_desc_type desc;
   tal_desc_type q_data;
   logic         q_full;
   logic         q_empty;
   logic         q_pop;
   logic         accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // classify and update state
   tal_front #(
      .LOG_BYTES        (LOG_BYTES),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_item (req_item),
      .desc     (desc)
   );

   // decoupling queue
   tal_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (desc),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   // result sequencing
   tal_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
